@@ src/rtcacc_pkg.sv @@
// ----------------------------------------------------------------------------
// RTC elapsed time accumulator package
// Shared field widths, payload types, calendar constants and month-length
// helper functions.
// ----------------------------------------------------------------------------
package rtcacc_pkg;

	localparam int HOURS_WIDTH_DEF = 16;

	localparam int YEAR_W     = 7;
	localparam int MONTH_W    = 4;
	localparam int DAY_W      = 5;
	localparam int HOUR_W     = 5;
	localparam int MINUTE_W   = 6;
	localparam int SECOND_W   = 6;
	localparam int TOT_HOURS_W = 16;
	localparam int LIMIT_W    = 16;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

	localparam int SECS_PER_MIN    = 60;
	localparam int MINS_PER_HOUR   = 60;
	localparam int HOURS_PER_DAY   = 24;
	localparam int MONTHS_PER_YEAR = 12;
	localparam int CENTURY         = 100;
	localparam int LEAP_CYCLE      = 400;

	// Day sum, month count and walking year widths.
	localparam int DSUM_W  = 17;
	localparam int MCNT_W  = 11;
	localparam int WYEAR_W = 9;

	localparam logic ACT_ACCUM = 1'b0;
	localparam logic ACT_LOAD  = 1'b1;

	localparam logic [MONTH_W-1:0] JAN = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] FEB = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] APR = MONTH_W'(4);
	localparam logic [MONTH_W-1:0] JUN = MONTH_W'(6);
	localparam logic [MONTH_W-1:0] SEP = MONTH_W'(9);
	localparam logic [MONTH_W-1:0] NOV = MONTH_W'(11);
	localparam logic [MONTH_W-1:0] DEC = MONTH_W'(12);

	localparam logic [4:0] LEN_31 = 5'd31;
	localparam logic [4:0] LEN_30 = 5'd30;
	localparam logic [4:0] LEN_29 = 5'd29;
	localparam logic [4:0] LEN_28 = 5'd28;

	typedef logic [LIMIT_W-1:0] limit_t;

	typedef struct packed {
		logic                action;
		logic                skip;
		logic [YEAR_W-1:0]   cur_year;
		logic [MONTH_W-1:0]  cur_month;
		logic [DAY_W-1:0]    cur_day;
		logic [HOUR_W-1:0]   cur_hour;
		logic [MINUTE_W-1:0] cur_minute;
		logic [SECOND_W-1:0] cur_second;
	} item_t;

	typedef struct packed {
		logic [TOT_HOURS_W-1:0] total_hours;
		logic [MINUTE_W-1:0]    total_minutes;
		logic [SECOND_W-1:0]    total_seconds;
		logic                   limit_reached;
		logic                   applied;
	} result_t;

	typedef struct packed {
		logic [MONTH_W-1:0]        month;
		logic [WYEAR_W-1:0]        year;
		logic [MCNT_W-1:0]         count;
		logic signed [DSUM_W-1:0]  day;
	} walk_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} walk_stat_t;

	// Gregorian rule on the year within the century span the walk can reach.
	function automatic logic is_leap(input logic [WYEAR_W-1:0] yr);
		logic century_hit;
		century_hit = (yr == WYEAR_W'(CENTURY)) || (yr == WYEAR_W'(2 * CENTURY)) ||
			(yr == WYEAR_W'(3 * CENTURY)) || (yr == WYEAR_W'(LEAP_CYCLE + CENTURY));
		return (yr[1:0] == 2'b00) && !century_hit;
	endfunction

	function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
		logic [4:0] len;
		len = LEN_31;
		if (m == APR || m == JUN || m == SEP || m == NOV) begin
			len = LEN_30;
		end else if (m == FEB) begin
			len = leap ? LEN_29 : LEN_28;
		end
		return len;
	endfunction

endpackage

@@ src/rtcacc_chan_if.sv @@
// ----------------------------------------------------------------------------
// RTC elapsed time accumulator channel
// Valid/ready channel carrying one payload beat of a chosen type.
// ----------------------------------------------------------------------------
interface rtcacc_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ src/rtcacc_month_walk.sv @@
// ----------------------------------------------------------------------------
// RTC elapsed time accumulator month walker
// Adds one month length per cycle to a day sum, stepping month and year.
// ----------------------------------------------------------------------------
module rtcacc_month_walk (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  rtcacc_pkg::walk_req_t              req,
	output rtcacc_pkg::walk_stat_t             stat,
	output logic signed [rtcacc_pkg::DSUM_W-1:0] day_sum
);

	logic                                   busy_q;
	logic [rtcacc_pkg::MONTH_W-1:0]         month_q;
	logic [rtcacc_pkg::WYEAR_W-1:0]         year_q;
	logic [rtcacc_pkg::MCNT_W-1:0]          count_q;
	logic signed [rtcacc_pkg::DSUM_W-1:0]   day_q;
	logic [4:0]                             len;
	logic signed [rtcacc_pkg::DSUM_W-1:0]   len_ext;
	logic                                   last;

	assign last    = (count_q == '0);
	assign len     = rtcacc_pkg::month_len(month_q, rtcacc_pkg::is_leap(year_q));
	assign len_ext = signed'(rtcacc_pkg::DSUM_W'(len));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			month_q <= req.month;
			year_q  <= req.year;
			count_q <= req.count;
			day_q   <= req.day;
		end else if (busy_q && !last) begin
			day_q   <= day_q + len_ext;
			count_q <= count_q - 1'b1;
			if (month_q == rtcacc_pkg::DEC) begin
				month_q <= rtcacc_pkg::JAN;
				year_q  <= year_q + 1'b1;
			end else begin
				month_q <= month_q + 1'b1;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && last;
	assign day_sum   = day_q;

endmodule

@@ src/rtc_elapsed_time_accumulator.sv @@
// ----------------------------------------------------------------------------
// RTC elapsed time accumulator
// Adds the time elapsed since a stored reference clock reading to a running
// hours:minutes:seconds total.
// ----------------------------------------------------------------------------
// Usage: each beat on item carries a clock reading with an action and a skip
// bit. Every accepted beat yields exactly one beat on result with the totals,
// the sticky limit flag and whether the beat was applied. The cfg channel
// writes the limit in hours and is always ready; the limit is to be written
// only while the block is idle, which the block itself does not enforce.
// Sequence: a skipped, load or unreferenced beat passes through the diff and
// output states. An accumulate beat passes through diff, walk, hours, sat and
// output, where the walk covers N months (month difference plus twelve per
// year, up to 1538) and the month walker adds one month length per cycle.
// Throughput: one beat at a time; item is ready only while the sequencer idles,
// which it does again as soon as a result has been registered.
// Reset clears the reference reading, the totals and the flag, and sets the
// limit to 100 hours. A stalled receiver holds the result register; the block
// still accepts one more beat and works it up to the point of delivery.
// ----------------------------------------------------------------------------
module rtc_elapsed_time_accumulator #(
	parameter int HOURS_WIDTH = rtcacc_pkg::HOURS_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	rtcacc_chan_if.sink   item,
	rtcacc_chan_if.source result,
	rtcacc_chan_if.sink   cfg
);

	localparam int HSUM_W = HOURS_WIDTH + 24;
	localparam int DH_W   = 22;
	localparam int CMP_W  = (HOURS_WIDTH > rtcacc_pkg::LIMIT_W) ? HOURS_WIDTH :
		rtcacc_pkg::LIMIT_W;

	localparam logic signed [7:0] SIXTY_S     = 8'(rtcacc_pkg::SECS_PER_MIN);
	localparam logic signed [7:0] TWO_SIXTY_S = 8'(2 * rtcacc_pkg::SECS_PER_MIN);
	localparam logic signed [HSUM_W-1:0] HMAX_S =
		signed'(HSUM_W'({HOURS_WIDTH{1'b1}}));

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_DIFF  = 6'b000010,
		S_WALK  = 6'b000100,
		S_HOURS = 6'b001000,
		S_SAT   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t                                state_q;
	rtcacc_pkg::item_t                     item_q;
	rtcacc_pkg::limit_t                    limit_q;
	rtcacc_pkg::result_t                   res_q;
	logic                                  res_valid_q;

	logic [rtcacc_pkg::YEAR_W-1:0]         ref_year_q;
	logic [rtcacc_pkg::MONTH_W-1:0]        ref_month_q;
	logic [rtcacc_pkg::DAY_W-1:0]          ref_day_q;
	logic [rtcacc_pkg::HOUR_W-1:0]         ref_hour_q;
	logic [rtcacc_pkg::MINUTE_W-1:0]       ref_minute_q;
	logic [rtcacc_pkg::SECOND_W-1:0]       ref_second_q;
	logic [HOURS_WIDTH-1:0]                acc_hours_q;
	logic [rtcacc_pkg::MINUTE_W-1:0]       acc_min_q;
	logic [rtcacc_pkg::SECOND_W-1:0]       acc_sec_q;
	logic                                  flag_q;

	logic                                  applied_q;
	logic                                  check_q;
	logic [rtcacc_pkg::SECOND_W-1:0]       sec_q;
	logic [rtcacc_pkg::MINUTE_W-1:0]       min_q;
	logic signed [7:0]                     hr_q;
	logic signed [DH_W-1:0]                dh_q;

	logic                                  accum_ok;
	logic                                  walk_start;
	rtcacc_pkg::walk_req_t                 walk_req;
	rtcacc_pkg::walk_stat_t                walk_stat;
	logic signed [rtcacc_pkg::DSUM_W-1:0]  walk_day;

	logic signed [7:0]                     s_raw, s_adj, s_brw;
	logic signed [7:0]                     m_raw, m_adj, m_brw;
	logic signed [7:0]                     h_raw;
	logic signed [7:0]                     y_raw;
	logic signed [5:0]                     d_raw;
	logic signed [11:0]                    mo_total;
	logic [rtcacc_pkg::MONTH_W-1:0]        start_month;

	logic [6:0]                            se_sum, mi_sum;
	logic                                  se_carry, mi_carry;
	logic [rtcacc_pkg::SECOND_W-1:0]       se_new;
	logic [rtcacc_pkg::MINUTE_W-1:0]       mi_new;
	logic signed [DH_W-1:0]                day_x, dh_next;

	logic signed [HSUM_W-1:0]              h_sum;
	logic [HOURS_WIDTH-1:0]                h_sat;
	logic                                  res_free;
	logic                                  flag_next;

	// Difference of the reading against the reference, with borrows.
	always_comb begin
		s_raw = 8'({2'b00, item_q.cur_second}) - 8'({2'b00, ref_second_q});
		priority if (s_raw < -SIXTY_S) begin
			s_adj = s_raw + TWO_SIXTY_S;
			s_brw = -8'sd2;
		end else if (s_raw < 8'sd0) begin
			s_adj = s_raw + SIXTY_S;
			s_brw = -8'sd1;
		end else if (s_raw >= SIXTY_S) begin
			s_adj = s_raw - SIXTY_S;
			s_brw = 8'sd1;
		end else begin
			s_adj = s_raw;
			s_brw = 8'sd0;
		end

		m_raw = 8'({2'b00, item_q.cur_minute}) - 8'({2'b00, ref_minute_q}) + s_brw;
		priority if (m_raw < -SIXTY_S) begin
			m_adj = m_raw + TWO_SIXTY_S;
			m_brw = -8'sd2;
		end else if (m_raw < 8'sd0) begin
			m_adj = m_raw + SIXTY_S;
			m_brw = -8'sd1;
		end else if (m_raw >= SIXTY_S) begin
			m_adj = m_raw - SIXTY_S;
			m_brw = 8'sd1;
		end else begin
			m_adj = m_raw;
			m_brw = 8'sd0;
		end

		h_raw = 8'({3'b000, item_q.cur_hour}) - 8'({3'b000, ref_hour_q}) + m_brw;
		y_raw = 8'({1'b0, item_q.cur_year}) - 8'({1'b0, ref_year_q});
		d_raw = 6'({1'b0, item_q.cur_day}) - 6'({1'b0, ref_day_q});

		mo_total = 12'({8'h00, item_q.cur_month}) - 12'({8'h00, ref_month_q});
		if (y_raw > 8'sd0) begin
			mo_total = mo_total + 12'(y_raw) * 12'(rtcacc_pkg::MONTHS_PER_YEAR);
		end

		if (ref_month_q > rtcacc_pkg::DEC) begin
			start_month = ref_month_q - rtcacc_pkg::DEC;
		end else begin
			start_month = ref_month_q;
		end
	end

	assign accum_ok   = !item_q.skip && (item_q.action == rtcacc_pkg::ACT_ACCUM) &&
		(ref_day_q != '0) && (ref_month_q != '0);
	assign walk_start = (state_q == S_DIFF) && accum_ok;

	assign walk_req.month = start_month;
	assign walk_req.year  = rtcacc_pkg::WYEAR_W'(ref_year_q);
	assign walk_req.count = (mo_total > 12'sd0) ? mo_total[rtcacc_pkg::MCNT_W-1:0] : '0;
	assign walk_req.day   = rtcacc_pkg::DSUM_W'(d_raw);

	rtcacc_month_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (walk_start),
		.req     (walk_req),
		.stat    (walk_stat),
		.day_sum (walk_day)
	);

	// Minute and second totals with their carries, and the hour delta.
	always_comb begin
		se_sum   = 7'(acc_sec_q) + 7'(sec_q);
		se_carry = (se_sum >= 7'(rtcacc_pkg::SECS_PER_MIN));
		se_new   = se_carry ? rtcacc_pkg::SECOND_W'(se_sum - 7'(rtcacc_pkg::SECS_PER_MIN)) :
			rtcacc_pkg::SECOND_W'(se_sum);
		mi_sum   = 7'(acc_min_q) + 7'(min_q) + 7'(se_carry);
		mi_carry = (mi_sum >= 7'(rtcacc_pkg::MINS_PER_HOUR));
		mi_new   = mi_carry ? rtcacc_pkg::MINUTE_W'(mi_sum - 7'(rtcacc_pkg::MINS_PER_HOUR)) :
			rtcacc_pkg::MINUTE_W'(mi_sum);
		day_x    = DH_W'(walk_day);
		dh_next  = (day_x <<< 4) + (day_x <<< 3) + DH_W'(hr_q) +
			signed'(DH_W'(mi_carry));
	end

	// Hour total with saturation at zero and at the register maximum.
	always_comb begin
		h_sum = signed'(HSUM_W'(acc_hours_q)) + HSUM_W'(dh_q);
		priority if (h_sum[HSUM_W-1]) begin
			h_sat = '0;
		end else if (h_sum > HMAX_S) begin
			h_sat = '1;
		end else begin
			h_sat = h_sum[HOURS_WIDTH-1:0];
		end
	end

	assign res_free  = !res_valid_q || result.ready;
	assign flag_next = flag_q ||
		(check_q && (CMP_W'(acc_hours_q) >= CMP_W'(limit_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					state_q <= accum_ok ? S_WALK : S_OUT;
				end
				S_WALK: begin
					if (walk_stat.done) begin
						state_q <= S_HOURS;
					end
				end
				S_HOURS: begin
					state_q <= S_SAT;
				end
				S_SAT: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_year_q   <= '0;
			ref_month_q  <= '0;
			ref_day_q    <= '0;
			ref_hour_q   <= '0;
			ref_minute_q <= '0;
			ref_second_q <= '0;
			acc_hours_q  <= '0;
			acc_min_q    <= '0;
			acc_sec_q    <= '0;
			flag_q       <= 1'b0;
			limit_q      <= rtcacc_pkg::LIMIT_RESET;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.data;
			end
			if ((state_q == S_DIFF) && !item_q.skip &&
				((item_q.action == rtcacc_pkg::ACT_LOAD) || accum_ok)) begin
				ref_year_q   <= item_q.cur_year;
				ref_month_q  <= item_q.cur_month;
				ref_day_q    <= item_q.cur_day;
				ref_hour_q   <= item_q.cur_hour;
				ref_minute_q <= item_q.cur_minute;
				ref_second_q <= item_q.cur_second;
			end
			if (state_q == S_HOURS) begin
				acc_min_q <= mi_new;
				acc_sec_q <= se_new;
			end
			if (state_q == S_SAT) begin
				acc_hours_q <= h_sat;
			end
			if ((state_q == S_OUT) && res_free) begin
				flag_q      <= flag_next;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_q <= item.data;
		end
		if (state_q == S_DIFF) begin
			applied_q <= !item_q.skip &&
				((item_q.action == rtcacc_pkg::ACT_LOAD) || accum_ok);
			check_q   <= accum_ok;
			sec_q     <= rtcacc_pkg::SECOND_W'(s_adj);
			min_q     <= rtcacc_pkg::MINUTE_W'(m_adj);
			hr_q      <= h_raw;
		end
		if (state_q == S_HOURS) begin
			dh_q <= dh_next;
		end
		if ((state_q == S_OUT) && res_free) begin
			res_q.total_hours   <= rtcacc_pkg::TOT_HOURS_W'(acc_hours_q);
			res_q.total_minutes <= acc_min_q;
			res_q.total_seconds <= acc_sec_q;
			res_q.limit_reached <= flag_next;
			res_q.applied       <= applied_q;
		end
	end

	assign item.ready   = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	a_walk_in_walk_state: assert property (@(posedge clk) disable iff (!arst_n)
		walk_stat.busy |-> (state_q == S_WALK))
		else $error("Month walker busy outside the walk state.");

	a_result_normalized: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.data.total_minutes <
			rtcacc_pkg::MINUTE_W'(rtcacc_pkg::MINS_PER_HOUR)) &&
			(result.data.total_seconds < rtcacc_pkg::SECOND_W'(rtcacc_pkg::SECS_PER_MIN))))
		else $error("Result minutes or seconds out of range.");

	a_flag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		flag_q |=> flag_q)
		else $error("Limit flag dropped after being set.");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		walk_start |=> !item.ready)
		else $error("Input ready while an accumulate beat is in progress.");

endmodule

@@ verif/tb_rtc_elapsed_time_accumulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC elapsed time accumulator testbench
// Sends clock readings through the item channel and checks every result beat
// against a table expectation or an in-bench calendar predictor. The run starts
// with a table of directed readings, then sends random reading sequences under
// three limit settings and three patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_rtc_elapsed_time_accumulator;

	import rtcacc_pkg::*;

	localparam int HOURS_W     = HOURS_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int PLAN_LEN    = 25;

	typedef struct {
		item_t   it;
		logic    typed;
		result_t want;
	} step_row_t;

	logic clk;
	logic arst_n;

	rtcacc_chan_if #(.T(item_t))   item_ch ();
	rtcacc_chan_if #(.T(result_t)) result_ch ();
	rtcacc_chan_if #(.T(limit_t))  cfg_ch ();

	rtc_elapsed_time_accumulator #(
		.HOURS_WIDTH(HOURS_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	// Predictor state, mirroring the block after reset.
	item_t   ref_rd      = '0;
	longint  acc_hours   = 0;
	longint  acc_minutes = 0;
	longint  acc_seconds = 0;
	logic    limit_flag  = 1'b0;
	longint  limit_val   = LIMIT_RESET;

	result_t   expected_totals[$];
	int        mismatches     = 0;
	int        send_idle_pct  = 12;
	int        recv_stall_pct = 54;
	longint    cycles         = 0;
	item_t     clock_rd;
	step_row_t plan [PLAN_LEN];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int month_length(input int m, input longint yr);
		case (m)
			APR, JUN, SEP, NOV: return LEN_30;
			FEB: begin
				if (yr % LEAP_CYCLE == 0) return LEN_29;
				if (yr % CENTURY == 0) return LEN_28;
				if (yr % 4 == 0) return LEN_29;
				return LEN_28;
			end
			default: return LEN_31;
		endcase
	endfunction

	function automatic result_t accumulate_reading(input item_t it);
		longint  dy, dmo, dd, dh, dmi, ds, yr, mref, h, mi, se, hmax;
		int      m;
		logic    applied;
		result_t r;
		applied = 1'b0;
		hmax = (longint'(1) << HOURS_W) - 1;
		if (!it.skip) begin
			if (it.action == ACT_LOAD) begin
				ref_rd = it;
				applied = 1'b1;
			end else if (ref_rd.cur_day != '0 && ref_rd.cur_month != '0) begin
				dy  = longint'(it.cur_year) - longint'(ref_rd.cur_year);
				dmo = longint'(it.cur_month) - longint'(ref_rd.cur_month);
				dd  = longint'(it.cur_day) - longint'(ref_rd.cur_day);
				dh  = longint'(it.cur_hour) - longint'(ref_rd.cur_hour);
				dmi = longint'(it.cur_minute) - longint'(ref_rd.cur_minute);
				ds  = longint'(it.cur_second) - longint'(ref_rd.cur_second);
				while (ds < 0) begin
					dmi--;
					ds += SECS_PER_MIN;
				end
				while (ds >= SECS_PER_MIN) begin
					dmi++;
					ds -= SECS_PER_MIN;
				end
				while (dmi < 0) begin
					dh--;
					dmi += MINS_PER_HOUR;
				end
				// The minute difference carries into hours only once upward.
				if (dmi >= MINS_PER_HOUR) begin
					dh++;
					dmi -= MINS_PER_HOUR;
				end
				if (dy > 0) dmo += dy * MONTHS_PER_YEAR;
				yr   = ref_rd.cur_year;
				mref = ref_rd.cur_month;
				for (longint k = 0; k < dmo; k++) begin
					m = int'((mref - 1 + k) % MONTHS_PER_YEAR) + 1;
					dd += month_length(m, yr);
					if (m == MONTHS_PER_YEAR) yr++;
				end
				h  = acc_hours + dd * HOURS_PER_DAY + dh;
				mi = acc_minutes + dmi;
				se = acc_seconds + ds;
				while (se >= SECS_PER_MIN) begin
					mi++;
					se -= SECS_PER_MIN;
				end
				while (mi >= MINS_PER_HOUR) begin
					h++;
					mi -= MINS_PER_HOUR;
				end
				if (h < 0) h = 0;
				if (h > hmax) h = hmax;
				acc_hours   = h;
				acc_minutes = mi;
				acc_seconds = se;
				if (acc_hours >= limit_val) limit_flag = 1'b1;
				ref_rd  = it;
				applied = 1'b1;
			end
		end
		r.total_hours   = acc_hours[TOT_HOURS_W-1:0];
		r.total_minutes = acc_minutes[MINUTE_W-1:0];
		r.total_seconds = acc_seconds[SECOND_W-1:0];
		r.limit_reached = limit_flag;
		r.applied       = applied;
		return r;
	endfunction

	function automatic item_t rd(input logic action, input logic skip, input int y,
		input int mo, input int d, input int h, input int mi, input int s);
		item_t it;
		it.action     = action;
		it.skip       = skip;
		it.cur_year   = YEAR_W'(y);
		it.cur_month  = MONTH_W'(mo);
		it.cur_day    = DAY_W'(d);
		it.cur_hour   = HOUR_W'(h);
		it.cur_minute = MINUTE_W'(mi);
		it.cur_second = SECOND_W'(s);
		return it;
	endfunction

	function automatic result_t res(input int h, input int mi, input int s,
		input logic flag, input logic applied);
		result_t r;
		r.total_hours   = TOT_HOURS_W'(h);
		r.total_minutes = MINUTE_W'(mi);
		r.total_seconds = SECOND_W'(s);
		r.limit_reached = flag;
		r.applied       = applied;
		return r;
	endfunction

	// Moves the running reading on: in about half the calls within the same day,
	// otherwise by a day or a month, and now and then by one to twelve years.
	function automatic void advance_clock();
		int unsigned step;
		int          y;
		step = $urandom_range(9);
		if ($urandom_range(59) == 0) begin
			y = int'(clock_rd.cur_year) + int'($urandom_range(12, 1));
			clock_rd.cur_year = YEAR_W'((y > 99) ? 99 : y);
		end else if (step >= 5) begin
			if (step >= 8 || clock_rd.cur_day >= LEN_28) begin
				if (clock_rd.cur_month >= DEC) begin
					clock_rd.cur_month = JAN;
					clock_rd.cur_year  = (clock_rd.cur_year >= YEAR_W'(99)) ? '0 :
						clock_rd.cur_year + 1'b1;
				end else begin
					clock_rd.cur_month = clock_rd.cur_month + 1'b1;
				end
			end
			if (step < 8) begin
				clock_rd.cur_day = (clock_rd.cur_day >= LEN_28) ? DAY_W'(1) :
					clock_rd.cur_day + 1'b1;
			end
		end
		clock_rd.cur_hour   = HOUR_W'($urandom_range(23));
		clock_rd.cur_minute = MINUTE_W'($urandom_range(59));
		clock_rd.cur_second = SECOND_W'($urandom_range(59));
	endfunction

	function automatic item_t random_reading();
		logic [63:0] raw;
		int unsigned pick;
		item_t       it;
		pick = $urandom_range(99);
		raw  = {$urandom, $urandom};
		if (pick < 8) return raw[$bits(item_t)-1:0];
		if (pick < 20) begin
			// Arbitrary in-range reading, often earlier than the reference.
			if (raw[40]) clock_rd.cur_year = YEAR_W'($urandom_range(99));
			clock_rd.cur_month  = MONTH_W'($urandom_range(12, 1));
			clock_rd.cur_day    = DAY_W'($urandom_range(31, 1));
			clock_rd.cur_hour   = HOUR_W'($urandom_range(23));
			clock_rd.cur_minute = MINUTE_W'($urandom_range(59));
			clock_rd.cur_second = SECOND_W'($urandom_range(59));
		end else begin
			advance_clock();
		end
		it        = clock_rd;
		it.action = (pick >= 20 && pick < 32) ? ACT_LOAD : ACT_ACCUM;
		it.skip   = (pick >= 32 && pick < 38);
		if (it.skip) it.action = raw[0];
		return it;
	endfunction

	task automatic push_reading(input item_t it, input logic typed, input result_t want);
		result_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		do @(posedge clk); while (!item_ch.ready);
		pred = accumulate_reading(it);
		expected_totals.push_back(typed ? want : pred);
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (expected_totals.size() != 0) @(posedge clk);
	endtask

	task automatic write_limit(input limit_t value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		limit_val = value;
	endtask

	initial begin
		result_t got, want;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				got = result_ch.data;
				if (expected_totals.size() == 0) begin
					$error("result beat with no expectation waiting");
					mismatches++;
				end else begin
					want = expected_totals.pop_front();
					if (got.total_hours !== want.total_hours) begin
						$error("total_hours: expected %0d, actual %0d",
							want.total_hours, got.total_hours);
						mismatches++;
					end
					if (got.total_minutes !== want.total_minutes) begin
						$error("total_minutes: expected %0d, actual %0d",
							want.total_minutes, got.total_minutes);
						mismatches++;
					end
					if (got.total_seconds !== want.total_seconds) begin
						$error("total_seconds: expected %0d, actual %0d",
							want.total_seconds, got.total_seconds);
						mismatches++;
					end
					if (got.limit_reached !== want.limit_reached) begin
						$error("limit_reached: expected %0d, actual %0d",
							want.limit_reached, got.limit_reached);
						mismatches++;
					end
					if (got.applied !== want.applied) begin
						$error("applied: expected %0d, actual %0d",
							want.applied, got.applied);
						mismatches++;
					end
				end
			end
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data  = '0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.data   = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan = '{
			'{rd(ACT_ACCUM, 1'b0, 24, 5, 17, 12, 30, 0), 1'b1, res(0, 0, 0, 1'b0, 1'b0)},
			'{rd(ACT_LOAD, 1'b1, 24, 5, 17, 12, 30, 0), 1'b1, res(0, 0, 0, 1'b0, 1'b0)},
			'{rd(ACT_ACCUM, 1'b1, 24, 5, 18, 12, 30, 0), 1'b1, res(0, 0, 0, 1'b0, 1'b0)},
			'{rd(ACT_LOAD, 1'b0, 5, 3, 0, 8, 0, 0), 1'b1, res(0, 0, 0, 1'b0, 1'b1)},
			'{rd(ACT_ACCUM, 1'b0, 5, 3, 9, 8, 0, 0), 1'b1, res(0, 0, 0, 1'b0, 1'b0)},
			'{rd(ACT_LOAD, 1'b0, 5, 0, 15, 8, 0, 0), 1'b1, res(0, 0, 0, 1'b0, 1'b1)},
			'{rd(ACT_ACCUM, 1'b0, 5, 4, 15, 8, 0, 0), 1'b1, res(0, 0, 0, 1'b0, 1'b0)},
			'{rd(ACT_LOAD, 1'b0, 10, 6, 10, 0, 0, 0), 1'b1, res(0, 0, 0, 1'b0, 1'b1)},
			'{rd(ACT_ACCUM, 1'b0, 10, 6, 14, 3, 0, 0), 1'b1, res(99, 0, 0, 1'b0, 1'b1)},
			'{rd(ACT_ACCUM, 1'b0, 10, 6, 14, 4, 0, 0), 1'b1, res(100, 0, 0, 1'b1, 1'b1)},
			'{rd(ACT_ACCUM, 1'b0, 10, 6, 14, 3, 59, 30), 1'b0, '0},
			'{rd(ACT_ACCUM, 1'b0, 10, 6, 1, 0, 0, 0), 1'b0, '0},
			'{rd(ACT_LOAD, 1'b0, 0, 2, 28, 23, 59, 59), 1'b0, '0},
			'{rd(ACT_ACCUM, 1'b0, 0, 2, 29, 0, 0, 0), 1'b0, '0},
			'{rd(ACT_ACCUM, 1'b0, 0, 3, 1, 0, 0, 1), 1'b0, '0},
			'{rd(ACT_ACCUM, 1'b0, 1, 3, 1, 0, 0, 1), 1'b0, '0},
			'{rd(ACT_LOAD, 1'b0, 99, 12, 31, 23, 59, 59), 1'b0, '0},
			'{rd(ACT_ACCUM, 1'b0, 99, 12, 31, 23, 59, 59), 1'b0, '0},
			'{rd(ACT_ACCUM, 1'b0, 0, 1, 1, 0, 0, 0), 1'b0, '0},
			'{rd(ACT_LOAD, 1'b0, 0, 1, 1, 0, 0, 0), 1'b0, '0},
			'{rd(ACT_ACCUM, 1'b0, 127, 15, 31, 31, 63, 63), 1'b0, '0},
			'{rd(ACT_LOAD, 1'b0, 127, 15, 31, 31, 63, 63), 1'b0, '0},
			'{rd(ACT_ACCUM, 1'b0, 0, 0, 0, 0, 0, 0), 1'b0, '0},
			'{rd(ACT_LOAD, 1'b0, 5, 14, 1, 0, 0, 0), 1'b0, '0},
			'{rd(ACT_ACCUM, 1'b0, 6, 14, 1, 0, 0, 0), 1'b0, '0}
		};
		foreach (plan[n]) push_reading(plan[n].it, plan[n].typed, plan[n].want);

		wait_drained();
		write_limit(limit_t'(16'hFFFF));
		clock_rd = rd(ACT_ACCUM, 1'b0, $urandom_range(30), $urandom_range(12, 1),
			$urandom_range(28, 1), 0, 0, 0);
		for (int n = 0; n < 170; n++) begin
			if (n == 60) wait_drained();
			push_reading(random_reading(), 1'b0, '0);
		end

		wait_drained();
		send_idle_pct  = 54;
		recv_stall_pct = 12;
		write_limit('0);
		repeat (170) push_reading(random_reading(), 1'b0, '0);

		wait_drained();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_limit(limit_t'($urandom_range(65535)));
		repeat (160) push_reading(random_reading(), 1'b0, '0);

		wait_drained();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_totals.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
